/* src/plti_pkg.sv */
package plti_pkg;

  localparam int unsigned POINTS_DEF = 64;
  localparam int unsigned CNT_W      = 7;
  localparam int unsigned VAL_W      = 24;

  typedef enum logic [1:0] {
    REQ_ADD      = 2'd0,
    REQ_EVAL     = 2'd1,
    REQ_CLASSIFY = 2'd2,
    REQ_NONE     = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    SH_VARIABLE   = 3'd0,
    SH_DECREASING = 3'd1,
    SH_INCREASING = 3'd2,
    SH_CONSTANT   = 3'd3,
    SH_NONE       = 3'd4
  } shape_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_ADD_RD,
    S_ADD_CHK,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_DIV,
    S_CLS_RD,
    S_CLS_CHK,
    S_FINISH,
    S_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;        // capture the request
    logic rd_issue;    // read entry at idx-1 (add) or idx (scan)
    logic rd_first;    // read at idx itself (eval/classify scan)
    logic idx_dec;     // step index down
    logic idx_inc;     // step index up
    logic shift_wr;    // write entry idx from read data (shift up)
    logic ins_wr;      // write new point at idx
    logic cnt_inc;
    logic eval_step;   // evaluate compare of current entry
    logic cls_step;    // classify compare of current entry
    logic div_start;
    logic res_set;     // build the result
    logic out_load;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    req_t req;
    logic full;
    logic empty;
    logic idx_zero;     // index at 0
    logic idx_last;     // index at count-1
    logic add_stop;     // previous entry x <= new x
    logic eval_done;    // evaluate decided at this entry
    logic eval_div;     // decided and needs the divider
    logic div_busy;
    logic out_busy;
    logic out_take;
  } dp_sts_t;

endpackage

/* src/plti_div.sv */
module plti_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [47:0] num_mag,
  input  logic [16:0] den,
  input  logic        neg,
  output logic        busy,
  output logic [47:0] quo
);
  // restoring divider, one quotient bit per cycle
  logic [47:0] q_r, q_nxt;
  logic [17:0] rem_r, rem_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        neg_r;
  logic [17:0] trial;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = {rem_r[16:0], q_r[47]} - {1'b0, den};
    if (start) begin
      q_nxt    = num_mag;
      rem_nxt  = '0;
      cnt_nxt  = 6'd48;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[17]) begin
        rem_nxt = trial;
        q_nxt   = {q_r[46:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[16:0], q_r[47]};
        q_nxt   = {q_r[46:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) neg_r <= neg;
  end

  assign busy = busy_r;
  assign quo  = neg_r ? -q_r : q_r;
endmodule

/* src/plti_datapath.sv */
module plti_datapath #(
  parameter int unsigned POINTS = plti_pkg::POINTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  plti_pkg::dp_cmd_t cmd,
  output plti_pkg::dp_sts_t sts,
  input  logic              in_tvalid,
  input  logic [39:0]       in_tdata,
  input  logic              out_tready,
  output logic              out_tvalid,
  output logic [71:0]       out_tdata
);
  import plti_pkg::*;

  localparam int unsigned AW = (POINTS > 1) ? $clog2(POINTS) : 1;
  localparam int unsigned CW = $clog2(POINTS + 1);

  logic [31:0] mem_r [POINTS];

  req_t             req_r;
  logic signed [15:0] xq_r, yq_r;
  logic [CW-1:0]    count_r;
  logic [CW-1:0]    idx_r;
  logic [31:0]      rd_r;
  logic signed [15:0] px_r, py_r;   // previous entry
  logic             have_prev_r;
  logic             up_r, down_r, flat_r;
  logic signed [15:0] minx_r;
  logic [1:0]       st_r;
  logic signed [23:0] val_r;
  logic             eval_div_r;
  logic             out_v_r;
  logic [71:0]      out_d_r;

  logic signed [15:0] rx, ry;
  assign rx = rd_r[15:0];
  assign ry = rd_r[31:16];

  // memory: one write, one read port
  logic [AW-1:0] wa, ra;
  logic          we;
  logic [31:0]   wd;
  always_comb begin
    we = cmd.shift_wr || cmd.ins_wr;
    wa = idx_r[AW-1:0];
    wd = cmd.ins_wr ? {yq_r, xq_r} : rd_r;
    ra = cmd.rd_first ? idx_r[AW-1:0] : (idx_r[AW-1:0] - AW'(1));
  end
  always_ff @(posedge clk) begin
    if (we) mem_r[wa] <= wd;
    if (cmd.rd_issue) rd_r <= mem_r[ra];
  end

  // eval decision on the current entry rx (index idx_r) with prev px
  logic ev_done, ev_div;
  logic [1:0] ev_st;
  logic signed [23:0] ev_val;
  always_comb begin
    ev_done = 1'b0; ev_div = 1'b0; ev_st = ST_OK;
    ev_val  = 24'(ry) <<< 8;
    if (!have_prev_r && xq_r < rx) begin
      ev_done = 1'b1; ev_st = ST_RANGE;
    end else if (xq_r == rx) begin
      ev_done = 1'b1;
    end else if (have_prev_r && xq_r < rx) begin
      ev_done = 1'b1; ev_div = 1'b1;
    end else if (sts.idx_last) begin
      ev_done = 1'b1; ev_st = ST_RANGE;
    end
  end

  // divider operands
  logic signed [17:0] dh, dl;
  logic signed [34:0] num;
  logic [47:0] nmag;
  logic divbusy;
  logic [47:0] quo;
  assign dh   = 18'(rx) - 18'(xq_r);
  assign dl   = 18'(xq_r) - 18'(px_r);
  logic signed [34:0] p1_r, p2_r;
  logic [16:0] den_r;
  always_ff @(posedge clk) begin
    if (cmd.eval_step) begin
      p1_r  <= 35'(dh) * 35'(py_r);
      p2_r  <= 35'(dl) * 35'(ry);
      den_r <= 17'(rx - px_r);
    end
  end
  assign num  = p1_r + p2_r;
  assign nmag = num[34] ? 48'(-num) << 8 : 48'(num) << 8;

  plti_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
    .num_mag(nmag), .den(den_r), .neg(num[34]),
    .busy(divbusy), .quo(quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (cmd.cnt_inc) count_r <= count_r + CW'(1);
      if (cmd.out_load) out_v_r <= 1'b1;
      else if (out_tready) out_v_r <= 1'b0;
    end
    if (cmd.load) begin
      req_r <= req_t'(in_tdata[1:0]);
      xq_r  <= in_tdata[17:2];
      yq_r  <= in_tdata[33:18];
      idx_r <= (in_tdata[1:0] == REQ_ADD) ? count_r : '0;
      have_prev_r <= 1'b0;
      up_r <= 1'b0; down_r <= 1'b0; flat_r <= 1'b0;
      st_r <= ST_OK; val_r <= '0; eval_div_r <= 1'b0;
    end
    if (cmd.idx_dec) idx_r <= idx_r - CW'(1);
    if (cmd.idx_inc) idx_r <= idx_r + CW'(1);
    if (cmd.eval_step) begin
      px_r <= rx; py_r <= ry; have_prev_r <= 1'b1;
      if (ev_done) begin
        st_r <= ev_st; val_r <= ev_val; eval_div_r <= ev_div;
      end
    end
    if (cmd.cls_step) begin
      if (!have_prev_r) minx_r <= rx;
      else if (ry > py_r) up_r <= 1'b1;
      else if (ry < py_r) down_r <= 1'b1;
      else flat_r <= 1'b1;
      px_r <= rx; py_r <= ry; have_prev_r <= 1'b1;
    end
    if (cmd.res_set) begin
      logic [1:0] s;
      logic [23:0] v;
      logic [2:0] sh;
      logic [15:0] mn, mx;
      s = ST_OK; v = '0; sh = SH_NONE; mn = '0; mx = '0;
      unique case (req_r)
        REQ_ADD: s = (count_r == CW'(POINTS) && !eval_div_r && idx_r == count_r)
                     ? ST_FULL : ST_OK;
        REQ_EVAL: begin
          if (count_r == '0) s = ST_EMPTY;
          else begin
            s = st_r;
            v = eval_div_r ? quo[23:0] : val_r;
          end
        end
        REQ_CLASSIFY: begin
          if (count_r == '0) s = ST_EMPTY;
          else begin
            mn = minx_r; mx = px_r;
            if (up_r && down_r) sh = SH_VARIABLE;
            else if (down_r && !flat_r) sh = SH_DECREASING;
            else if (up_r && !flat_r) sh = SH_INCREASING;
            else if (flat_r && !up_r && !down_r) sh = SH_CONSTANT;
          end
        end
        default: s = ST_OK;
      endcase
      out_d_r <= {4'b0, 7'(count_r), mx, mn, sh, v, s};
    end
  end

  always_comb begin
    sts.req       = req_r;
    sts.full      = (count_r == CW'(POINTS));
    sts.empty     = (count_r == '0);
    sts.idx_zero  = (idx_r == '0);
    sts.idx_last  = (idx_r == count_r - CW'(1));
    sts.add_stop  = !(rx > xq_r);
    sts.eval_done = ev_done;
    sts.eval_div  = ev_div;
    sts.div_busy  = divbusy;
    sts.out_busy  = out_v_r;
    sts.out_take  = out_v_r && out_tready;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;

  logic unused;
  assign unused = in_tvalid ^ ^in_tdata[39:34];
endmodule

/* src/plti_ctrl.sv */
module plti_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  plti_pkg::dp_sts_t sts,
  output plti_pkg::dp_cmd_t cmd
);
  import plti_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (in_tvalid) state_nxt = S_DISPATCH;
      S_DISPATCH: begin
        unique case (sts.req)
          REQ_ADD:      state_nxt = sts.full ? S_FINISH
                                  : (sts.idx_zero ? S_ADD_CHK : S_ADD_RD);
          REQ_EVAL:     state_nxt = sts.empty ? S_FINISH : S_SCAN_RD;
          REQ_CLASSIFY: state_nxt = sts.empty ? S_FINISH : S_CLS_RD;
          default:      state_nxt = S_FINISH;
        endcase
      end
      S_ADD_RD:   state_nxt = S_ADD_CHK;
      S_ADD_CHK:  state_nxt = (sts.idx_zero || sts.add_stop) ? S_FINISH : S_ADD_RD;
      S_SCAN_RD:  state_nxt = S_SCAN_CHK;
      S_SCAN_CHK: state_nxt = sts.eval_done ? (sts.eval_div ? S_DIV : S_FINISH)
                                             : S_SCAN_RD;
      S_DIV:      state_nxt = S_FINISH;
      S_CLS_RD:   state_nxt = S_CLS_CHK;
      S_CLS_CHK:  state_nxt = sts.idx_last ? S_FINISH : S_CLS_RD;
      S_FINISH:   if (!sts.div_busy && !sts.out_busy) state_nxt = S_OUT;
      S_OUT:      state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      S_DISPATCH: ;
      S_ADD_RD: cmd.rd_issue = 1'b1;
      S_ADD_CHK: begin
        // add_stop: entry idx-1 stays, new point goes at idx
        if (sts.idx_zero || sts.add_stop) begin
          cmd.ins_wr  = 1'b1;
          cmd.cnt_inc = 1'b1;
        end else begin
          cmd.shift_wr = 1'b1;
          cmd.idx_dec  = 1'b1;
        end
      end
      S_SCAN_RD: begin
        cmd.rd_issue = 1'b1;
        cmd.rd_first = 1'b1;
      end
      S_SCAN_CHK: begin
        cmd.eval_step = 1'b1;
        if (!sts.eval_done) cmd.idx_inc = 1'b1;
      end
      S_DIV: cmd.div_start = 1'b1;
      S_CLS_RD: begin
        cmd.rd_issue = 1'b1;
        cmd.rd_first = 1'b1;
      end
      S_CLS_CHK: begin
        cmd.cls_step = 1'b1;
        if (!sts.idx_last) cmd.idx_inc = 1'b1;
      end
      S_FINISH: ;
      S_OUT: begin
        cmd.res_set  = 1'b1;
        cmd.out_load = 1'b1;
      end
      default: ;
    endcase
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.shift_wr |-> !cmd.ins_wr) else $error("shift and insert together");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) |-> !sts.div_busy) else $error("result while dividing");
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (state_r == S_IDLE)) else $error("ready while busy");
endmodule

/* src/piecewise_linear_table_interp.sv */
// Piecewise linear interpolation table.
// in_*  : request beats. in_tdata = {pad, y_value[15:0], x_value[15:0], req_type[1:0]}.
//         req_type 0 adds a point (kept sorted by x, stable), 1 evaluates at x,
//         2 classifies the table's shape.
// out_* : one result beat per request. out_tdata = {pad, point_count, max_x,
//         min_x, shape_class, interp_value, status}, status in the lowest bits.
// Timing: one request at a time. Add walks down from the end shifting entries,
// each entry read from the table and then written back one place up. Evaluate
// scans up from entry 0 and, when x falls between two points, runs a restoring
// divider on the bracketing points. Classify scans all entries.
// The next request is accepted in the cycle after the result is loaded.
// Reset clears the point count, the output valid and the control and divider
// state; table contents are never read before they are written. The result
// register holds while out_tready is low; the next request is still processed,
// then waits for the register to drain before loading its result, and holds
// in_tready low until then.
module piecewise_linear_table_interp #(
  parameter int unsigned POINTS = plti_pkg::POINTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // req_type, x_value, y_value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata   // status, interp_value, shape_class, min_x, max_x, point_count
);
  import plti_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  plti_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .sts(sts), .cmd(cmd)
  );

  plti_datapath #(.POINTS(POINTS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_tvalid(in_tvalid), .in_tdata(in_tdata),
    .out_tready(out_tready), .out_tvalid(out_tvalid), .out_tdata(out_tdata)
  );
endmodule

/* sim/tb_piecewise_linear_table_interp.sv */
`timescale 1ns / 100ps

module tb_piecewise_linear_table_interp;
  import plti_pkg::*;

  localparam int unsigned TBL_DEPTH = POINTS_DEF;

  // One result beat, unpacked from out_tdata (last field in the lowest bits).
  typedef struct packed {
    logic [6:0]  point_count;
    logic [15:0] max_x;
    logic [15:0] min_x;
    shape_t      shape_class;
    logic [23:0] interp_value;
    status_t     status;
  } interp_result_t;

  // One row of the directed table; chk marks rows whose result is typed in.
  typedef struct {
    req_t           req;
    logic [15:0]    x;
    logic [15:0]    y;
    bit             chk;
    interp_result_t res;
  } directed_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;

  // Predictor state: its own copy of the sorted point table.
  logic signed [15:0] pts_x [TBL_DEPTH];
  logic signed [15:0] pts_y [TBL_DEPTH];
  int unsigned        pts_count;

  interp_result_t pending_results[$];
  int unsigned    error_count;
  int unsigned    results_seen;
  int unsigned    evals_interp;
  int unsigned    full_hits;
  bit             drain_stall;      // receiver random stalls on/off
  bit             hold_off_req;     // ask receiver for a long hold-off
  bit             hold_off_active;

  piecewise_linear_table_interp u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic interp_result_t pack_result(status_t st, logic signed [23:0] v, shape_t sh,
                                                 logic [15:0] mn, logic [15:0] mx);
    interp_result_t r;
    r.status       = st;
    r.interp_value = v;
    r.shape_class  = sh;
    r.min_x        = mn;
    r.max_x        = mx;
    r.point_count  = pts_count[6:0];
    return r;
  endfunction

  // Insert a point after all stored points with x <= new x.
  function automatic status_t table_insert(logic signed [15:0] x, logic signed [15:0] y);
    int pos;
    if (pts_count >= TBL_DEPTH) begin
      return ST_FULL;
    end
    pos = pts_count;
    while (pos > 0 && pts_x[pos-1] > x) begin
      pts_x[pos] = pts_x[pos-1];
      pts_y[pos] = pts_y[pos-1];
      pos--;
    end
    pts_x[pos] = x;
    pts_y[pos] = y;
    pts_count++;
    return ST_OK;
  endfunction

  function automatic interp_result_t table_evaluate(logic signed [15:0] q);
    longint num, xl, xh;
    int n;
    n = pts_count;
    if (n == 0) begin
      return pack_result(ST_EMPTY, 24'sd0, SH_NONE, 16'd0, 16'd0);
    end
    if (q < pts_x[0]) begin
      return pack_result(ST_RANGE, 24'(longint'(pts_y[0]) * 256), SH_NONE, 16'd0, 16'd0);
    end
    if (q > pts_x[n-1]) begin
      return pack_result(ST_RANGE, 24'(longint'(pts_y[n-1]) * 256), SH_NONE, 16'd0, 16'd0);
    end
    for (int i = 0; i < n; i++) begin
      if (pts_x[i] == q) begin
        return pack_result(ST_OK, 24'(longint'(pts_y[i]) * 256), SH_NONE, 16'd0, 16'd0);
      end
    end
    for (int i = 0; i + 1 < n; i++) begin
      xl = pts_x[i];
      xh = pts_x[i+1];
      if (xl < q && q < xh) begin
        evals_interp++;
        num = (xh - q) * longint'(pts_y[i]) + (q - xl) * longint'(pts_y[i+1]);
        return pack_result(ST_OK, 24'((num * 256) / (xh - xl)), SH_NONE, 16'd0, 16'd0);
      end
    end
    return pack_result(ST_OK, 24'sd0, SH_NONE, 16'd0, 16'd0);
  endfunction

  function automatic interp_result_t table_classify();
    int rises, falls, flats;
    shape_t sh;
    rises = 0;
    falls = 0;
    flats = 0;
    if (pts_count == 0) begin
      return pack_result(ST_EMPTY, 24'sd0, SH_NONE, 16'd0, 16'd0);
    end
    for (int i = 0; i + 1 < pts_count; i++) begin
      if (pts_y[i+1] > pts_y[i]) rises++;
      else if (pts_y[i+1] < pts_y[i]) falls++;
      else flats++;
    end
    if (falls > 0 && rises > 0) sh = SH_VARIABLE;
    else if (falls > 0 && flats == 0) sh = SH_DECREASING;
    else if (rises > 0 && flats == 0) sh = SH_INCREASING;
    else if (flats > 0 && rises == 0 && falls == 0) sh = SH_CONSTANT;
    else sh = SH_NONE;
    return pack_result(ST_OK, 24'sd0, sh, pts_x[0], pts_x[pts_count-1]);
  endfunction

  function automatic interp_result_t predict_interp(req_t req, logic [15:0] x, logic [15:0] y);
    status_t st;
    case (req)
      REQ_ADD: begin
        st = table_insert(x, y);
        if (st == ST_FULL) full_hits++;
        return pack_result(st, 24'sd0, SH_NONE, 16'd0, 16'd0);
      end
      REQ_EVAL:     return table_evaluate(x);
      REQ_CLASSIFY: return table_classify();
      default:      return pack_result(ST_OK, 24'sd0, SH_NONE, 16'd0, 16'd0);
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH @%0t result %0d: %s got %h want %h", $realtime, results_seen, what,
             got, want);
    error_count++;
  endtask

  // Drive one request beat; an idle burst may come before it when gaps are on.
  task automatic send_request(req_t req, logic [15:0] x, logic [15:0] y, bit gaps);
    if (gaps && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, y, x, req};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(predict_interp(req, x, y));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Random x mostly from a narrow window, unless wide is set, so adds, exact hits and brackets meet.
  function automatic logic [15:0] rand_coord(bit wide);
    if (wide || $urandom_range(0, 7) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 400) - 200);
  endfunction

  task automatic random_phase(int unsigned items, int unsigned fill, bit gaps);
    int unsigned r;
    req_t req;
    bit wide;
    wide = $urandom_range(0, 3) == 0;
    for (int unsigned k = 0; k < items; k++) begin
      r = $urandom_range(0, 99);
      if (pts_count < fill && r < 70) req = REQ_ADD;
      else if (r < 12) req = REQ_ADD;
      else if (r < 85) req = REQ_EVAL;
      else if (r < 97) req = REQ_CLASSIFY;
      else req = REQ_NONE;
      send_request(req, rand_coord(wide), 16'($urandom), gaps);
    end
  endtask

  // The table cannot be restarted: the only way to empty it is reset, which
  // the bench does not repeat, so phases just keep adding and rely on the
  // full-table add.
  directed_row_t rows[$];

  function automatic interp_result_t typed_result(status_t st, logic [23:0] v, shape_t sh,
                                                  logic [15:0] mn, logic [15:0] mx,
                                                  logic [6:0] cnt);
    interp_result_t r;
    r.status       = st;
    r.interp_value = v;
    r.shape_class  = sh;
    r.min_x        = mn;
    r.max_x        = mx;
    r.point_count  = cnt;
    return r;
  endfunction

  // Stimulus.
  initial begin
    interp_result_t want;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    rst_n       = 1'b0;
    pts_count   = 0;
    error_count = 0;
    drain_stall = 1'b1;
    hold_off_req = 1'b0;

    // Empty-table cases and field extremes, then a mixed small table.
    rows.push_back('{REQ_EVAL, 16'h0000, 16'h0000, 1,
                     typed_result(ST_EMPTY, 24'd0, SH_NONE, 16'd0, 16'd0, 7'd0)});
    rows.push_back('{REQ_CLASSIFY, 16'hFFFF, 16'hFFFF, 1,
                     typed_result(ST_EMPTY, 24'd0, SH_NONE, 16'd0, 16'd0, 7'd0)});
    rows.push_back('{REQ_NONE, 16'hFFFF, 16'hFFFF, 1,
                     typed_result(ST_OK, 24'd0, SH_NONE, 16'd0, 16'd0, 7'd0)});
    rows.push_back('{REQ_ADD, 16'h0000, 16'h7FFF, 1,
                     typed_result(ST_OK, 24'd0, SH_NONE, 16'd0, 16'd0, 7'd1)});
    rows.push_back('{REQ_CLASSIFY, 16'h0000, 16'h0000, 1,
                     typed_result(ST_OK, 24'd0, SH_NONE, 16'd0, 16'd0, 7'd1)});
    rows.push_back('{REQ_EVAL, 16'h0000, 16'h0000, 1,
                     typed_result(ST_OK, 24'h7FFF00, SH_NONE, 16'd0, 16'd0, 7'd1)});
    rows.push_back('{REQ_ADD, 16'h7FFF, 16'h8000, 0, '0});
    rows.push_back('{REQ_ADD, 16'h8000, 16'h8000, 0, '0});
    rows.push_back('{REQ_EVAL, 16'h8000, 16'h0000, 1,
                     typed_result(ST_OK, 24'h800000, SH_NONE, 16'd0, 16'd0, 7'd3)});
    rows.push_back('{REQ_EVAL, 16'h7FFF, 16'h0000, 1,
                     typed_result(ST_OK, 24'h800000, SH_NONE, 16'd0, 16'd0, 7'd3)});
    rows.push_back('{REQ_EVAL, 16'h4000, 16'h0000, 0, '0});
    rows.push_back('{REQ_EVAL, 16'hC000, 16'h0000, 0, '0});
    rows.push_back('{REQ_CLASSIFY, 16'h0000, 16'h0000, 1,
                     typed_result(ST_OK, 24'd0, SH_VARIABLE, 16'h8000, 16'h7FFF, 7'd3)});
    // duplicate x: exact match returns the first stored y
    rows.push_back('{REQ_ADD, 16'h0000, 16'h0001, 0, '0});
    rows.push_back('{REQ_EVAL, 16'h0000, 16'h0000, 1,
                     typed_result(ST_OK, 24'h7FFF00, SH_NONE, 16'd0, 16'd0, 7'd4)});
    rows.push_back('{REQ_EVAL, 16'h0001, 16'h0000, 0, '0});
    rows.push_back('{REQ_EVAL, 16'hFFFF, 16'h5555, 0, '0});
    rows.push_back('{REQ_CLASSIFY, 16'h0000, 16'h0000, 0, '0});

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (rows[i]) begin
      send_request(rows[i].req, rows[i].x, rows[i].y, 1'b1);
      if (rows[i].chk && pending_results[$] !== rows[i].res) begin
        report_mismatch($sformatf("typed row %0d", i), 32'(pending_results[$]),
                        32'(rows[i].res));
      end
    end

    // Sender pauses until every result has come back.
    wait_drained();

    // Long receiver hold-off while the sender keeps offering beats.
    hold_off_req = 1'b1;
    random_phase(8, 0, 1'b0);
    hold_off_req = 1'b0;

    // Fill the table to full with random content, hitting the full status.
    random_phase(500, TBL_DEPTH, 1'b1);
    while (pts_count < TBL_DEPTH) send_request(REQ_ADD, rand_coord(0), 16'($urandom), 1'b1);
    send_request(REQ_ADD, 16'h7FFF, 16'h7FFF, 1'b1);
    want = pending_results[$];
    if (want.status != ST_FULL)
      report_mismatch("full-table add", 32'(want.status), 32'(ST_FULL));

    random_phase(850, TBL_DEPTH, 1'b1);
    wait_drained();

    // Last stretch with no idling on either side.
    drain_stall = 1'b0;
    random_phase(300, TBL_DEPTH, 1'b0);
    wait_drained();
    repeat (200) @(negedge clk);

    $display("Covered %0d results: %0d interpolating evaluates, %0d adds to a full table,",
             results_seen, evals_interp, full_hits);
    $display("plus empty, exact-match, duplicate-x, out-of-range and classify cases.");
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    int unsigned hold_cycles;
    out_tready      = 1'b0;
    hold_off_active = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off_req && !hold_off_active) begin
        hold_off_active = 1'b1;
        out_tready <= 1'b0;
        hold_cycles = 0;
        while (hold_cycles < 1500) begin
          @(negedge clk);
          hold_cycles++;
        end
      end else if (drain_stall && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 6) - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Compare each accepted result beat with the oldest expectation.
  always @(posedge clk) begin
    interp_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[67:0];
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected beat", 32'(got.status), 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status)
          report_mismatch("status", 32'(got.status), 32'(want.status));
        if (got.interp_value !== want.interp_value)
          report_mismatch("interp_value", 32'(got.interp_value), 32'(want.interp_value));
        if (got.shape_class !== want.shape_class)
          report_mismatch("shape_class", 32'(got.shape_class), 32'(want.shape_class));
        if (got.min_x !== want.min_x)
          report_mismatch("min_x", 32'(got.min_x), 32'(want.min_x));
        if (got.max_x !== want.max_x)
          report_mismatch("max_x", 32'(got.max_x), 32'(want.max_x));
        if (got.point_count !== want.point_count)
          report_mismatch("point_count", 32'(got.point_count), 32'(want.point_count));
        if (out_tdata[71:68] !== 4'b0000)
          report_mismatch("pad bits", 32'(out_tdata[71:68]), 32'd0);
      end
    end
  end

  // Watchdog: a time budget for ~1700 items, with stalls, many times over.
  initial begin
    #50ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

/* piecewise_linear_table_interp.f */
src/plti_pkg.sv
src/plti_div.sv
src/plti_datapath.sv
src/plti_ctrl.sv
src/piecewise_linear_table_interp.sv
sim/tb_piecewise_linear_table_interp.sv
